@@ rtl/htss_pkg.sv @@
// Shared types, codes and command tables for the humidity/temperature sensor sequencer.
// No dependencies; used by htss_cfg, htss_core, htss_emit and the top level.
`timescale 1ns / 1ps
package htss_pkg;

	// event codes carried by req_type
	localparam logic [1:0] REQ_MEASURE = 2'd0;
	localparam logic [1:0] REQ_INIT    = 2'd1;
	localparam logic [1:0] REQ_TICK    = 2'd2;
	localparam logic [1:0] REQ_BYTE    = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_WAIT_MS     = 2'd0;
	localparam logic [1:0] REG_COOLDOWN_MS = 2'd1;
	localparam logic [1:0] REG_DEVICE_ADDR = 2'd2;

	localparam logic [7:0]  WAIT_MS_RST     = 8'd10;
	localparam logic [15:0] COOLDOWN_MS_RST = 16'd1000;
	localparam logic [6:0]  DEVICE_ADDR_RST = 7'h38;

	// sensor command bytes
	localparam logic [7:0] BYTE_TRIGGER  = 8'hAC;
	localparam logic [7:0] BYTE_TRIG_ARG = 8'h33;
	localparam logic [7:0] BYTE_CAL_A    = 8'hA8;
	localparam logic [7:0] BYTE_CAL_B    = 8'hBE;
	localparam logic [7:0] BYTE_CAL_ARG  = 8'h08;
	localparam logic [7:0] BYTE_ZERO     = 8'h00;

	localparam int unsigned NUM_DATA_BYTES = 5;
	localparam logic [6:0]  HUM_SCALE      = 7'd100;
	localparam logic [7:0]  TEMP_SCALE     = 8'd200;
	localparam logic [8:0]  TEMP_OFFSET    = 9'd50;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WAIT,
		PH_STATUS,
		PH_DATA,
		PH_COOL
	} phase_t;

	typedef enum logic [2:0] {
		CMD_START_W = 3'd0,
		CMD_START_R = 3'd1,
		CMD_SEND    = 3'd2,
		CMD_RX_ACK  = 3'd3,
		CMD_RX_NAK  = 3'd4,
		CMD_STOP    = 3'd5,
		CMD_MEAS    = 3'd6
	} cmd_kind_t;

	// one burst of bus commands caused by a single request
	typedef enum logic [2:0] {
		BU_NONE,
		BU_TRIGGER,
		BU_INIT,
		BU_STATUS,
		BU_STOP,
		BU_ACK,
		BU_NAK,
		BU_FINISH
	} burst_code_t;

	typedef struct packed {
		burst_code_t code;
		logic [6:0]  hum;
		logic [8:0]  temp;
	} burst_t;

	typedef struct packed {
		logic [7:0]  wait_ms;
		logic [15:0] cooldown_ms;
		logic [6:0]  device_addr;
	} cfg_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	function automatic logic [3:0] burst_len(input burst_code_t code);
		case (code)
			BU_TRIGGER: burst_len = 4'd5;
			BU_INIT:    burst_len = 4'd10;
			BU_STATUS:  burst_len = 4'd2;
			BU_FINISH:  burst_len = 4'd2;
			default:    burst_len = 4'd1;
		endcase
	endfunction

	function automatic cmd_t burst_item(input burst_code_t code, input logic [3:0] idx,
			input logic [6:0] addr);
		cmd_t c;
		c.kind = CMD_STOP;
		c.data = BYTE_ZERO;
		case (code)
			BU_TRIGGER: begin
				case (idx)
					4'd0: begin c.kind = CMD_START_W; c.data = {1'b0, addr}; end
					4'd1: begin c.kind = CMD_SEND; c.data = BYTE_TRIGGER; end
					4'd2: begin c.kind = CMD_SEND; c.data = BYTE_TRIG_ARG; end
					4'd3: begin c.kind = CMD_SEND; c.data = BYTE_ZERO; end
					default: c.kind = CMD_STOP;
				endcase
			end
			BU_INIT: begin
				case (idx)
					4'd0, 4'd5: begin c.kind = CMD_START_W; c.data = {1'b0, addr}; end
					4'd1: begin c.kind = CMD_SEND; c.data = BYTE_CAL_A; end
					4'd6: begin c.kind = CMD_SEND; c.data = BYTE_CAL_B; end
					4'd7: begin c.kind = CMD_SEND; c.data = BYTE_CAL_ARG; end
					4'd2, 4'd3, 4'd8: begin c.kind = CMD_SEND; c.data = BYTE_ZERO; end
					default: c.kind = CMD_STOP;
				endcase
			end
			BU_STATUS: begin
				if (idx == 4'd0) begin
					c.kind = CMD_START_R;
					c.data = {1'b0, addr};
				end else begin
					c.kind = CMD_RX_NAK;
				end
			end
			BU_ACK:    c.kind = CMD_RX_ACK;
			BU_NAK:    c.kind = CMD_RX_NAK;
			BU_FINISH: c.kind = (idx == 4'd0) ? CMD_STOP : CMD_MEAS;
			default:   c.kind = CMD_STOP;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/htss_req_if.sv @@
// Request channel: one sensor event (request, tick or received byte).
// Depends on nothing.
`timescale 1ns / 1ps
interface htss_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] rx_byte;

	modport source(output valid, req_type, rx_byte, input ready);
	modport sink(input valid, req_type, rx_byte, output ready);
endinterface

@@ rtl/htss_rsp_if.sv @@
// Result channel: one bus command or one measurement result.
// Depends on nothing.
`timescale 1ns / 1ps
interface htss_rsp_if;
	logic              valid;
	logic              ready;
	logic [2:0]        cmd_kind;
	logic [7:0]        cmd_byte;
	logic [6:0]        humidity_pct;
	logic signed [8:0] temperature_c;
	logic              last;

	modport source(output valid, cmd_kind, cmd_byte, humidity_pct, temperature_c, last,
		input ready);
	modport sink(input valid, cmd_kind, cmd_byte, humidity_pct, temperature_c, last,
		output ready);
endinterface

@@ rtl/htss_cfg.sv @@
// APB register file: wait time, cooldown time, device address.
// Depends on htss_pkg.
`timescale 1ns / 1ps
module htss_cfg import htss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);
	logic [7:0]  wait_ms_q;
	logic [15:0] cooldown_ms_q;
	logic [6:0]  device_addr_q;
	logic        wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_ms_q     <= WAIT_MS_RST;
			cooldown_ms_q <= COOLDOWN_MS_RST;
			device_addr_q <= DEVICE_ADDR_RST;
		end else if (wr) begin
			case (paddr[3:2])
				REG_WAIT_MS:     wait_ms_q     <= pwdata[7:0];
				REG_COOLDOWN_MS: cooldown_ms_q <= pwdata[15:0];
				REG_DEVICE_ADDR: device_addr_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WAIT_MS:     prdata = {24'd0, wait_ms_q};
			REG_COOLDOWN_MS: prdata = {16'd0, cooldown_ms_q};
			REG_DEVICE_ADDR: prdata = {25'd0, device_addr_q};
			default:         prdata = 32'd0;
		endcase
	end

	assign cfg = '{wait_ms: wait_ms_q, cooldown_ms: cooldown_ms_q, device_addr: device_addr_q};
endmodule

@@ rtl/htss_core.sv @@
// Input register and phase sequencer: updates the measurement state and picks
// the command burst for each event. Depends on htss_pkg and htss_req_if.
`timescale 1ns / 1ps
module htss_core import htss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	htss_req_if.sink    req,
	input  cfg_t        cfg,
	input  logic        burst_free,
	output logic        load_valid,
	output burst_t      load_burst
);
	logic        valid_s1;
	logic [1:0]  req_type_s1;
	logic [7:0]  rx_byte_s1;

	phase_t      phase_q, phase_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic [2:0]  byte_index_q, byte_index_d;
	logic [7:0]  data_q [NUM_DATA_BYTES];

	burst_code_t code;
	logic        fire;
	logic        wr_en;
	logic [2:0]  wr_idx;
	logic [2:0]  nxt_idx;
	logic [16:0] elapsed_inc;
	logic [15:0] elapsed_sat;

	logic [19:0] hraw, traw;
	logic [26:0] hprod;
	logic [27:0] tprod;
	logic [8:0]  temp;

	assign fire      = valid_s1 && ((code == BU_NONE) || burst_free);
	assign req.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1 <= req.req_type;
			rx_byte_s1  <= req.rx_byte;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			elapsed_q    <= 16'd0;
			byte_index_q <= 3'd0;
		end else if (fire) begin
			phase_q      <= phase_d;
			elapsed_q    <= elapsed_d;
			byte_index_q <= byte_index_d;
		end
	end

	// data byte store, no reset: the first four are read only after they are written; the fifth is taken from rx_byte_s1
	always_ff @(posedge clk) begin
		if (fire && wr_en) begin
			data_q[wr_idx] <= rx_byte_s1;
		end
	end

	assign elapsed_inc = {1'b0, elapsed_q} + 17'd1;
	assign elapsed_sat = elapsed_inc[16] ? 16'hFFFF : elapsed_inc[15:0];
	assign wr_idx      = (byte_index_q > 3'd4) ? 3'd4 : byte_index_q;
	assign nxt_idx     = wr_idx + 3'd1;

	// next state and burst selection
	always_comb begin
		phase_d      = phase_q;
		elapsed_d    = elapsed_q;
		byte_index_d = byte_index_q;
		code         = BU_NONE;
		wr_en        = 1'b0;
		case (req_type_s1)
			REQ_MEASURE: begin
				if (phase_q == PH_IDLE) begin
					code      = BU_TRIGGER;
					elapsed_d = 16'd0;
					phase_d   = PH_WAIT;
				end
			end
			REQ_INIT: begin
				if (phase_q == PH_IDLE) begin
					code = BU_INIT;
				end
			end
			REQ_TICK: begin
				if (phase_q == PH_WAIT) begin
					elapsed_d = elapsed_sat;
					if (elapsed_inc > {9'd0, cfg.wait_ms}) begin
						code    = BU_STATUS;
						phase_d = PH_STATUS;
					end
				end else if (phase_q == PH_COOL) begin
					elapsed_d = elapsed_sat;
					if (elapsed_inc > {1'b0, cfg.cooldown_ms}) begin
						phase_d   = PH_IDLE;
						elapsed_d = 16'd0;
					end
				end
			end
			REQ_BYTE: begin
				if (phase_q == PH_STATUS) begin
					if (rx_byte_s1[7]) begin
						// sensor busy: close the read, retry on a later tick
						code    = BU_STOP;
						phase_d = PH_WAIT;
					end else begin
						code         = BU_ACK;
						byte_index_d = 3'd0;
						phase_d      = PH_DATA;
					end
				end else if (phase_q == PH_DATA) begin
					wr_en        = 1'b1;
					byte_index_d = nxt_idx;
					if (nxt_idx < 3'd4) begin
						code = BU_ACK;
					end else if (nxt_idx == 3'd4) begin
						code = BU_NAK;
					end else begin
						code         = BU_FINISH;
						byte_index_d = 3'd0;
						elapsed_d    = 16'd0;
						phase_d      = PH_COOL;
					end
				end
			end
			default: ;
		endcase
	end

	// unpack: last byte is the one arriving now
	assign hraw  = {data_q[0], data_q[1], data_q[2][7:4]};
	assign traw  = {data_q[2][3:0], data_q[3], rx_byte_s1};
	assign hprod = 27'(hraw) * 27'(HUM_SCALE);
	assign tprod = 28'(traw) * 28'(TEMP_SCALE);
	assign temp  = {1'b0, tprod[27:20]} - TEMP_OFFSET;

	assign load_valid = fire && (code != BU_NONE);
	assign load_burst = '{code: code, hum: hprod[26:20], temp: temp};
endmodule

@@ rtl/htss_emit.sv @@
// Burst expander and output register: plays out one command per cycle while rsp is ready.
// Depends on htss_pkg and htss_rsp_if.
`timescale 1ns / 1ps
module htss_emit import htss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load_valid,
	input  burst_t      load_burst,
	input  logic [6:0]  device_addr,
	output logic        burst_free,
	htss_rsp_if.source  rsp
);
	logic       burst_valid_q;
	burst_t     burst_q;
	logic [3:0] idx_q;
	logic       out_valid_q;
	logic [2:0] kind_q;
	logic [7:0] byte_q;
	logic [6:0] hum_q;
	logic [8:0] temp_q;
	logic       last_q;

	cmd_t       cur;
	logic       last_of;
	logic       move;
	logic       is_meas;

	assign cur     = burst_item(burst_q.code, idx_q, device_addr);
	assign last_of = (idx_q == (burst_len(burst_q.code) - 4'd1));
	assign move    = burst_valid_q && (!out_valid_q || rsp.ready);
	assign is_meas = (cur.kind == CMD_MEAS);

	assign burst_free = !burst_valid_q || (move && last_of);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_valid_q <= 1'b0;
			idx_q         <= 4'd0;
		end else if (load_valid && burst_free) begin
			burst_valid_q <= 1'b1;
			idx_q         <= 4'd0;
		end else if (move) begin
			if (last_of) begin
				burst_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && burst_free) begin
			burst_q <= load_burst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			kind_q <= cur.kind;
			byte_q <= cur.data;
			hum_q  <= is_meas ? burst_q.hum : 7'd0;
			temp_q <= is_meas ? burst_q.temp : 9'd0;
			last_q <= last_of;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.cmd_kind      = kind_q;
	assign rsp.cmd_byte      = byte_q;
	assign rsp.humidity_pct  = hum_q;
	assign rsp.temperature_c = $signed(temp_q);
	assign rsp.last          = last_q;
endmodule

@@ rtl/humidity_temperature_sensor_sequencer.sv @@
// Humidity/temperature sensor sequencer, top level.
// Path: a request passes the input register, the burst register and the output register to rsp.
// Throughput: one request a cycle while each causes at most one command and rsp is ready;
//   a request that causes N commands (up to 10, calibration) holds the burst stage until all have moved on.
// Reset: arst_n clears phase, counters, handshakes and loads register defaults;
//   the five data byte registers are not reset.
`timescale 1ns / 1ps
module humidity_temperature_sensor_sequencer import htss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	htss_req_if.sink    req,
	htss_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	// configuration; the user must write it only while the sequencer is idle, the block does not enforce this
	cfg_t   cfg;
	// handoff of one command burst from the sequencer to the expander
	logic   burst_free;
	logic   load_valid;
	burst_t load_burst;

	htss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// request register, phase machine, byte store and the unpack multipliers
	htss_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg),
		.burst_free (burst_free),
		.load_valid (load_valid),
		.load_burst (load_burst)
	);

	// expands a burst into bus commands, behind an output register so that a
	// new request is taken while a finished command waits on rsp
	htss_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_valid  (load_valid),
		.load_burst  (load_burst),
		.device_addr (cfg.device_addr),
		.burst_free  (burst_free),
		.rsp         (rsp)
	);
endmodule
